// ===== rtl/jst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and constants for the streaming JSON tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam int MAX_DEPTH_DEF   = 32;
    localparam int OFFSET_BITS_DEF = 20;
    localparam int POS_W           = 20;
    localparam int DEPTH_W         = 6;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_BEGIN_OBJ = 4'd1,
        EV_BEGIN_ARR = 4'd2,
        EV_END_OBJ   = 4'd3,
        EV_END_ARR   = 4'd4,
        EV_TRUE      = 4'd5,
        EV_FALSE     = 4'd6,
        EV_NULL      = 4'd7,
        EV_STRING    = 4'd8,
        EV_INT       = 4'd9,
        EV_FLOAT     = 4'd10,
        EV_DONE      = 4'd11,
        EV_ERROR     = 4'd12
    } ev_t;

    localparam logic [3:0] ERR_NONE    = 4'd0;
    localparam logic [3:0] ERR_LIT     = 4'd1;
    localparam logic [3:0] ERR_KEY     = 4'd2;
    localparam logic [3:0] ERR_COLON   = 4'd3;
    localparam logic [3:0] ERR_BRACE   = 4'd4;
    localparam logic [3:0] ERR_BRACKET = 4'd5;
    localparam logic [3:0] ERR_CHAR    = 4'd6;
    localparam logic [3:0] ERR_DEEP    = 4'd7;
    localparam logic [3:0] ERR_STRING  = 4'd8;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_mark;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         event_kind;
        logic [POS_W-1:0]   value_start;
        logic [POS_W-1:0]   value_end;
        logic               has_name;
        logic [POS_W-1:0]   name_start;
        logic [POS_W-1:0]   name_end;
        logic [DEPTH_W-1:0] nest_depth;
        logic [3:0]         error_code;
        logic               last_of_item;
    } out_item_t;

    // Two results of one input item travel together to the output queue.
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } res_pair_t;

    function automatic logic [7:0] lit_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "t";
            4'd1:    c = "r";
            4'd2:    c = "u";
            4'd3:    c = "e";
            4'd4:    c = "f";
            4'd5:    c = "a";
            4'd6:    c = "l";
            4'd7:    c = "s";
            4'd8:    c = "e";
            4'd9:    c = "n";
            4'd10:   c = "u";
            4'd11:   c = "l";
            4'd12:   c = "l";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/jst_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_stack
// Container stack memory: one bit per level, 1 for object, 0 for array.
// ----------------------------------------------------------------------------
module jst_stack #(
    parameter int MAX_DEPTH = 32,
    parameter int AW        = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [MAX_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/jst_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_out_fifo
// Result queue that takes up to two results a cycle and gives one a cycle unless stalled.
// ----------------------------------------------------------------------------
module jst_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jst_pkg::res_pair_t   push_data,
    output logic                 room,
    output logic                 out_valid,
    output jst_pkg::out_item_t   out_data,
    input  logic                 out_stall
);
    import jst_pkg::*;

    localparam int DEPTH = 8;

    out_item_t   slot_reg [DEPTH];
    logic [2:0]  wp_reg, rp_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid = (cnt_reg != 4'd0);
    assign out_data  = slot_reg[rp_reg];
    assign pop       = out_valid && !out_stall;
    // Room for a worst-case pair even with nothing popped.
    assign room      = (cnt_reg <= 4'd6);

    always_comb
    begin
        cnt_next = cnt_reg - {3'd0, pop};
        if (push)
        begin
            cnt_next = cnt_next + (push_data.two ? 4'd2 : 4'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= push_data.first;
            if (push_data.two)
            begin
                slot_reg[wp_reg + 3'd1] <= push_data.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 3'd0;
            rp_reg  <= 3'd0;
            cnt_reg <= 4'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + (push_data.two ? 3'd2 : 3'd1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 3'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'd8) else $error("result queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg <= 4'd6) else $error("push without room");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

// ===== rtl/jst_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_core
// Grammar machine: one byte a cycle unless stalled, container kind kept in the stack memory.
// ----------------------------------------------------------------------------
module jst_core #(
    parameter int MAX_DEPTH   = 32,
    parameter int OFFSET_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  jst_pkg::in_item_t   in_data,
    output logic                push,
    output jst_pkg::res_pair_t  push_data
);
    import jst_pkg::*;

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam logic [OFFSET_BITS-1:0] POS_ONE = OFFSET_BITS'(1);
    localparam logic [CW-1:0]          CNT_ONE = CW'(1);
    localparam logic [CW-1:0]          CNT_TWO = CW'(2);

    typedef enum logic [4:0] {
        M_TOP_VALUE, M_ARR_VALUE, M_MEMBER_VALUE, M_OBJ_KEY, M_KEY_STR, M_KEY_ESC,
        M_COLON, M_OBJ_NEXT, M_ARR_NEXT, M_STR, M_STR_ESC, M_LIT, M_NUM_INT,
        M_NUM_FRAC, M_NUM_ESIGN, M_NUM_EXP, M_TAIL, M_FAULT
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [3:0]             lstep_reg, lstep_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] tok_reg, tok_next;
    logic [OFFSET_BITS-1:0] kb_reg, kb_next, ke_reg, ke_next;
    logic                   kv_reg, kv_next;
    logic [63:0]            nlo_reg, nlo_next;
    logic [1:0]             nhi_reg, nhi_next;
    logic                   neg_reg, neg_next;
    logic [3:0]             fault_reg, fault_next;

    // The top entry lives in a register. The memory read is always aimed at
    // the entry below the top, so after a pop the new top is already there.
    logic          st_rd;
    logic          wr_en, wr_data;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          top_obj_reg, top_obj_next;

    jst_stack #(.MAX_DEPTH(MAX_DEPTH), .AW(AW)) u_stack (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(st_rd)
    );

    // Digit accumulator step: times ten as two shifts and an add.
    logic [3:0]  dig;
    logic [67:0] acc_w;
    logic [63:0] acc_lo;
    logic [1:0]  acc_hi;
    always_comb
    begin
        acc_w = ({4'd0, nlo_reg} << 3) + ({4'd0, nlo_reg} << 1) + {64'd0, dig};
        if (nhi_reg != 2'd0 || acc_w[67:65] != 3'd0 || (acc_w[64] && acc_w[63:0] != 64'd0))
        begin
            acc_hi = 2'd2;
            acc_lo = (nhi_reg != 2'd0) ? nlo_reg : 64'd0;
        end
        else
        begin
            acc_hi = {1'b0, acc_w[64]};
            acc_lo = acc_w[63:0];
        end
    end

    out_item_t ev_a, ev_b;
    logic      n_ev;

    function automatic out_item_t mk(input logic [3:0] k, input logic [POS_W-1:0] vs,
                                      input logic [POS_W-1:0] ve, input logic nm,
                                      input logic [POS_W-1:0] ks,
                                      input logic [POS_W-1:0] kend,
                                      input logic [DEPTH_W-1:0] d, input logic [3:0] e);
        out_item_t o;
        o.event_kind   = k;
        o.value_start  = vs;
        o.value_end    = ve;
        o.has_name     = nm;
        o.name_start   = nm ? ks : '0;
        o.name_end     = nm ? kend : '0;
        o.nest_depth   = d;
        o.error_code   = e;
        o.last_of_item = 1'b0;
        return o;
    endfunction

    always_comb
    begin
        logic [7:0]             c;
        logic                   ws, isd, ise, took;
        logic [POS_W-1:0]       kbw, kew, tokw, posw;
        logic [DEPTH_W-1:0]     dep;
        logic [3:0]             kind;
        logic                   tobj;
        out_item_t              e;
        mode_next    = mode_reg;
        lstep_next   = lstep_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        tok_next     = tok_reg;
        kb_next      = kb_reg;
        ke_next      = ke_reg;
        kv_next      = kv_reg;
        nlo_next     = nlo_reg;
        nhi_next     = nhi_reg;
        neg_next     = neg_reg;
        fault_next   = fault_reg;
        top_obj_next = top_obj_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = 1'b0;
        n_ev         = 1'b0;
        push         = 1'b0;
        ev_a         = '0;
        ev_b         = '0;
        c            = in_data.char_code;
        ws           = (c <= 8'h20);
        isd          = (c >= "0") && (c <= "9");
        ise          = (c == "e") || (c == "E");
        dig          = c[3:0];
        took         = 1'b0;
        kbw          = POS_W'(kb_reg);
        kew          = POS_W'(ke_reg);
        tokw         = POS_W'(tok_reg);
        posw         = POS_W'(pos_reg);
        kind         = EV_NONE;
        tobj         = top_obj_reg;
        e            = '0;
        dep          = DEPTH_W'(cnt_reg);

        if (in_fire)
        begin
            // Finish a pending number first when the byte does not extend it.
            if (mode_reg == M_NUM_INT || mode_reg == M_NUM_FRAC ||
                mode_reg == M_NUM_ESIGN || mode_reg == M_NUM_EXP)
            begin
                if (!in_data.end_mark)
                begin
                    unique case (mode_reg)
                        M_NUM_INT:
                        begin
                            if (isd)
                            begin
                                took = 1'b1;
                                nlo_next = acc_lo;
                                nhi_next = acc_hi;
                            end
                            else if (c == ".")
                            begin
                                took = 1'b1;
                                mode_next = M_NUM_FRAC;
                            end
                            else if (ise)
                            begin
                                took = 1'b1;
                                mode_next = M_NUM_ESIGN;
                            end
                        end
                        M_NUM_FRAC:
                        begin
                            if (isd)
                            begin
                                took = 1'b1;
                            end
                            else if (ise)
                            begin
                                took = 1'b1;
                                mode_next = M_NUM_ESIGN;
                            end
                        end
                        M_NUM_ESIGN:
                        begin
                            if (c == "+" || c == "-" || isd)
                            begin
                                took = 1'b1;
                                mode_next = M_NUM_EXP;
                            end
                        end
                        default:
                        begin
                            took = isd;
                        end
                    endcase
                end
                if (!took)
                begin
                    kind = EV_FLOAT;
                    if (mode_reg == M_NUM_INT)
                    begin
                        if (neg_reg)
                        begin
                            kind = (nhi_reg != 2'd0 || nlo_reg > 64'h8000000000000000) ?
                                   EV_FLOAT : EV_INT;
                        end
                        else
                        begin
                            kind = (nhi_reg == 2'd2) ? EV_FLOAT : EV_INT;
                        end
                    end
                    ev_a = mk(kind, tokw, posw, kv_reg, kbw, kew, dep, ERR_NONE);
                    n_ev = 1'b1;
                    kv_next = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        mode_next = M_TAIL;
                    end
                    else
                    begin
                        mode_next = tobj ? M_OBJ_NEXT : M_ARR_NEXT;
                    end
                end
            end

            if (in_data.end_mark)
            begin
                if (mode_next == M_TAIL)
                begin
                    e = mk(EV_DONE, '0, '0, 1'b0, '0, '0, dep, ERR_NONE);
                end
                else
                begin
                    logic [3:0] code;
                    unique case (mode_next)
                        M_FAULT:   code = fault_reg;
                        M_OBJ_KEY: code = ERR_KEY;
                        M_COLON:   code = ERR_COLON;
                        M_OBJ_NEXT: code = ERR_BRACE;
                        M_ARR_NEXT: code = ERR_BRACKET;
                        M_KEY_STR, M_KEY_ESC, M_STR, M_STR_ESC: code = ERR_STRING;
                        M_LIT:     code = ERR_LIT;
                        default:   code = ERR_CHAR;
                    endcase
                    e = mk(EV_ERROR, '0, '0, 1'b0, '0, '0, dep, code);
                end
                if (n_ev)
                begin
                    ev_b = e;
                end
                else
                begin
                    ev_a = e;
                end
                mode_next  = M_TOP_VALUE;
                lstep_next = 4'd0;
                cnt_next   = '0;
                pos_next   = '0;
                tok_next   = '0;
                kb_next    = '0;
                ke_next    = '0;
                kv_next    = 1'b0;
                nlo_next   = '0;
                nhi_next   = '0;
                neg_next   = 1'b0;
                fault_next = '0;
                n_ev       = 1'b1;
                push       = 1'b1;
            end
            else if (!took)
            begin
                logic       emit;
                logic       is_fault;
                logic [3:0] fc;
                logic       do_open, open_obj, do_close;
                logic [3:0] close_kind;
                logic       do_val;
                logic [3:0] vkind;
                logic [POS_W-1:0] vs, ve;
                emit = 1'b0;
                is_fault = 1'b0;
                fc = ERR_NONE;
                do_open = 1'b0;
                open_obj = 1'b0;
                do_close = 1'b0;
                close_kind = EV_END_OBJ;
                do_val = 1'b0;
                vkind = EV_NONE;
                vs = '0;
                ve = '0;
                unique case (mode_next)
                    M_TOP_VALUE, M_ARR_VALUE, M_MEMBER_VALUE:
                    begin
                        if (!ws)
                        begin
                            if (c == "t" || c == "f" || c == "n")
                            begin
                                lstep_next = (c == "t") ? 4'd1 : (c == "f") ? 4'd5 : 4'd10;
                                mode_next  = M_LIT;
                            end
                            else if (c == "\"")
                            begin
                                tok_next  = pos_reg + POS_ONE;
                                mode_next = M_STR;
                            end
                            else if (c == "-" || c == "." || isd)
                            begin
                                tok_next = pos_reg;
                                nhi_next = 2'd0;
                                neg_next = (c == "-");
                                nlo_next = isd ? {60'd0, dig} : 64'd0;
                                mode_next = (c == ".") ? M_NUM_FRAC : M_NUM_INT;
                            end
                            else if (c == "[")
                            begin
                                do_open = 1'b1;
                            end
                            else if (c == "{")
                            begin
                                do_open = 1'b1;
                                open_obj = 1'b1;
                            end
                            else if (c == "]" && mode_next == M_ARR_VALUE)
                            begin
                                do_close = 1'b1;
                                close_kind = EV_END_ARR;
                            end
                            else
                            begin
                                is_fault = 1'b1;
                                fc = ERR_CHAR;
                            end
                        end
                    end
                    M_OBJ_KEY:
                    begin
                        if (!ws)
                        begin
                            if (c == "}")
                            begin
                                do_close = 1'b1;
                            end
                            else if (c == "\"")
                            begin
                                kb_next = pos_reg + POS_ONE;
                                mode_next = M_KEY_STR;
                            end
                            else
                            begin
                                is_fault = 1'b1;
                                fc = ERR_KEY;
                            end
                        end
                    end
                    M_KEY_STR:
                    begin
                        if (c == "\\")
                        begin
                            mode_next = M_KEY_ESC;
                        end
                        else if (c == "\"")
                        begin
                            ke_next = pos_reg;
                            kv_next = 1'b1;
                            mode_next = M_COLON;
                        end
                    end
                    M_KEY_ESC: mode_next = M_KEY_STR;
                    M_COLON:
                    begin
                        if (!ws)
                        begin
                            if (c == ":")
                            begin
                                mode_next = M_MEMBER_VALUE;
                            end
                            else
                            begin
                                is_fault = 1'b1;
                                fc = ERR_COLON;
                            end
                        end
                    end
                    M_OBJ_NEXT:
                    begin
                        if (!ws)
                        begin
                            if (c == ",")
                            begin
                                mode_next = M_OBJ_KEY;
                            end
                            else if (c == "}")
                            begin
                                do_close = 1'b1;
                            end
                            else
                            begin
                                is_fault = 1'b1;
                                fc = ERR_BRACE;
                            end
                        end
                    end
                    M_ARR_NEXT:
                    begin
                        if (!ws)
                        begin
                            if (c == ",")
                            begin
                                mode_next = M_ARR_VALUE;
                            end
                            else if (c == "]")
                            begin
                                do_close = 1'b1;
                                close_kind = EV_END_ARR;
                            end
                            else
                            begin
                                is_fault = 1'b1;
                                fc = ERR_BRACKET;
                            end
                        end
                    end
                    M_STR:
                    begin
                        if (c == "\\")
                        begin
                            mode_next = M_STR_ESC;
                        end
                        else if (c == "\"")
                        begin
                            do_val = 1'b1;
                            vkind = EV_STRING;
                            vs = tokw;
                            ve = posw;
                        end
                    end
                    M_STR_ESC: mode_next = M_STR;
                    M_LIT:
                    begin
                        if (lstep_reg > 4'd12 || c != lit_char(lstep_reg))
                        begin
                            is_fault = 1'b1;
                            fc = ERR_LIT;
                        end
                        else
                        begin
                            lstep_next = lstep_reg + 4'd1;
                            if (lstep_reg == 4'd3 || lstep_reg == 4'd8 || lstep_reg == 4'd12)
                            begin
                                do_val = 1'b1;
                                vkind = (lstep_reg == 4'd3) ? EV_TRUE :
                                        (lstep_reg == 4'd8) ? EV_FALSE : EV_NULL;
                                lstep_next = 4'd0;
                            end
                        end
                    end
                    default: ;
                endcase

                if (do_open)
                begin
                    if (cnt_reg >= CW'(MAX_DEPTH))
                    begin
                        is_fault = 1'b1;
                        fc = ERR_DEEP;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        wr_addr = AW'(cnt_reg);
                        wr_data = open_obj;
                        top_obj_next = open_obj;
                        cnt_next = cnt_reg + CNT_ONE;
                        e = mk(open_obj ? EV_BEGIN_OBJ : EV_BEGIN_ARR, '0, '0, kv_reg,
                               kbw, kew, DEPTH_W'(cnt_next), ERR_NONE);
                        emit = 1'b1;
                        kv_next = 1'b0;
                        mode_next = open_obj ? M_OBJ_KEY : M_ARR_VALUE;
                    end
                end
                if (do_close)
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - CNT_ONE;
                    end
                    // The entry below the old top is the prefetched memory word.
                    top_obj_next = st_rd;
                    e = mk(close_kind, '0, '0, 1'b0, '0, '0, DEPTH_W'(cnt_next), ERR_NONE);
                    emit = 1'b1;
                    mode_next = (cnt_next == '0) ? M_TAIL :
                                (st_rd ? M_OBJ_NEXT : M_ARR_NEXT);
                end
                if (do_val)
                begin
                    e = mk(vkind, vs, ve, kv_reg, kbw, kew, dep, ERR_NONE);
                    emit = 1'b1;
                    kv_next = 1'b0;
                    mode_next = (cnt_reg == '0) ? M_TAIL : (tobj ? M_OBJ_NEXT : M_ARR_NEXT);
                end
                if (is_fault)
                begin
                    fault_next = fc;
                    mode_next = M_FAULT;
                    e = mk(EV_ERROR, '0, '0, 1'b0, '0, '0, dep, fc);
                    emit = 1'b1;
                end
                if (emit)
                begin
                    if (n_ev)
                    begin
                        ev_b = e;
                    end
                    else
                    begin
                        ev_a = e;
                    end
                end
                pos_next = pos_reg + POS_ONE;
                n_ev = n_ev || emit;
                push = n_ev;
            end
            else
            begin
                pos_next = pos_reg + POS_ONE;
                push = n_ev;
            end
        end

        // Keep the read aimed at the entry under the top after this cycle.
        if (cnt_next >= CNT_TWO)
        begin
            rd_addr = AW'(cnt_next - CNT_TWO);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_comb
    begin
        push_data.two    = ev_b.event_kind != EV_NONE;
        push_data.first  = ev_a;
        push_data.second = ev_b;
        if (ev_b.event_kind != EV_NONE)
        begin
            push_data.second.last_of_item = 1'b1;
        end
        else
        begin
            push_data.first.last_of_item = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_TOP_VALUE;
            lstep_reg   <= 4'd0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            tok_reg     <= '0;
            kb_reg      <= '0;
            ke_reg      <= '0;
            kv_reg      <= 1'b0;
            nlo_reg     <= '0;
            nhi_reg     <= '0;
            neg_reg     <= 1'b0;
            fault_reg   <= '0;
            top_obj_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg    <= mode_next;
            lstep_reg   <= lstep_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            tok_reg     <= tok_next;
            kb_reg      <= kb_next;
            ke_reg      <= ke_next;
            kv_reg      <= kv_next;
            nlo_reg     <= nlo_next;
            nhi_reg     <= nhi_next;
            neg_reg     <= neg_next;
            fault_reg   <= fault_next;
            top_obj_reg <= top_obj_next;
        end
    end

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_DEPTH)) else $error("depth beyond limit");
    a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.end_mark) |=> (mode_reg == M_TOP_VALUE && cnt_reg == '0))
        else $error("end mark did not rearm");
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.end_mark) |-> push) else $error("end mark without result");

endmodule

// ===== rtl/json_stream_tokenizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_stream_tokenizer_top
// Streaming JSON tokenizer taking one byte per request.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload       Handshake
// in        input      in_item_t     in_valid / in_stall
// out       output     out_item_t    out_valid / out_stall
//
// One byte is taken per cycle unless in_stall; grammar step and stack write
// finish in the cycle of acceptance; results are registered in the out queue.
// The stack memory read is kept on the level below the top, so a container
// close does not wait on a memory read and requests can follow back to back.
// Reset clears all control state; the stack memory needs no clearing.
// Input stalls only when the result queue lacks room for two results.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_top #(
    parameter int MAX_DEPTH   = jst_pkg::MAX_DEPTH_DEF,
    parameter int OFFSET_BITS = jst_pkg::OFFSET_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  jst_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output jst_pkg::out_item_t  out_data
);
    import jst_pkg::*;

    logic      in_fire, push, room;
    res_pair_t pair;

    assign in_stall = !room;
    assign in_fire  = in_valid && !in_stall;

    jst_core #(.MAX_DEPTH(MAX_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_core (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_data(in_data),
        .push(push), .push_data(pair)
    );

    jst_out_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(pair), .room(room),
        .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
    );

endmodule

// ===== tb/json_stream_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_stream_tokenizer_top_tb
// Feeds JSON documents byte by byte, directed cases first, then random
// well-formed and damaged documents, and checks every token event against a
// behavioral tokenizer kept inside the bench, under random bursts and stalls.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_top_tb;
    import jst_pkg::*;

    typedef enum logic [4:0] {
        PS_TOP_VALUE, PS_ARR_VALUE, PS_MEMBER_VALUE, PS_OBJ_KEY, PS_KEY_STR,
        PS_KEY_ESC, PS_COLON, PS_OBJ_NEXT, PS_ARR_NEXT, PS_STR, PS_STR_ESC,
        PS_LIT, PS_NUM_INT, PS_NUM_FRAC, PS_NUM_ESIGN, PS_NUM_EXP, PS_TAIL,
        PS_FAULT
    } parse_state_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;

    json_stream_tokenizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    in_item_t  pending_bytes[$];
    out_item_t expected_events[$];
    out_item_t step_events[$];
    int        mismatch_count;
    int        events_seen;

    // Tokenizer state.
    parse_state_t    tk_mode;
    int              tk_lit_step;
    logic [63:0]     tk_stack;
    int              tk_depth;
    logic [POS_W-1:0] tk_offset;
    logic [POS_W-1:0] tk_token_begin;
    logic [POS_W-1:0] tk_key_begin;
    logic [POS_W-1:0] tk_key_end;
    bit              tk_key_valid;
    logic [63:0]     tk_num_low;
    logic [1:0]      tk_num_high;
    bit              tk_negative;
    logic [3:0]      tk_fault;

    task tk_reset();
        tk_mode = PS_TOP_VALUE;
        tk_lit_step = 0;
        tk_stack = '0;
        tk_depth = 0;
        tk_offset = '0;
        tk_token_begin = '0;
        tk_key_begin = '0;
        tk_key_end = '0;
        tk_key_valid = 0;
        tk_num_low = '0;
        tk_num_high = '0;
        tk_negative = 0;
        tk_fault = ERR_NONE;
    endtask

    task emit_event(input ev_t kind, input logic [POS_W-1:0] vs,
                    input logic [POS_W-1:0] ve, input bit named, input logic [3:0] err);
        out_item_t ev;
        if (step_events.size() < 2)
        begin
            ev = '0;
            ev.event_kind  = kind;
            ev.value_start = vs;
            ev.value_end   = ve;
            ev.has_name    = named;
            ev.name_start  = named ? tk_key_begin : '0;
            ev.name_end    = named ? tk_key_end : '0;
            ev.nest_depth  = tk_depth[DEPTH_W-1:0];
            ev.error_code  = err;
            step_events.push_back(ev);
        end
    endtask

    task emit_value(input ev_t kind, input logic [POS_W-1:0] vs, input logic [POS_W-1:0] ve);
        emit_event(kind, vs, ve, tk_key_valid, ERR_NONE);
        tk_key_valid = 0;
    endtask

    task raise_fault(input logic [3:0] code);
        tk_fault = code;
        tk_mode = PS_FAULT;
        emit_event(EV_ERROR, '0, '0, 0, code);
    endtask

    task after_value();
        if (tk_depth == 0)
            tk_mode = PS_TAIL;
        else
            tk_mode = tk_stack[tk_depth-1] ? PS_OBJ_NEXT : PS_ARR_NEXT;
    endtask

    task open_container(input bit is_obj);
        if (tk_depth >= MAX_DEPTH_DEF)
        begin
            raise_fault(ERR_DEEP);
        end
        else
        begin
            tk_stack[tk_depth] = is_obj;
            tk_depth++;
            emit_value(is_obj ? EV_BEGIN_OBJ : EV_BEGIN_ARR, '0, '0);
            tk_mode = is_obj ? PS_OBJ_KEY : PS_ARR_VALUE;
        end
    endtask

    task close_container(input ev_t kind);
        if (tk_depth > 0)
            tk_depth--;
        emit_event(kind, '0, '0, 0, ERR_NONE);
        after_value();
    endtask

    // Magnitude saturates: 1 in the high part means exactly 2^64, 2 means above.
    function void add_digit(input int d);
        logic [67:0] acc;
        if (tk_num_high != 0)
        begin
            tk_num_high = 2;
        end
        else
        begin
            acc = {4'd0, tk_num_low} * 68'd10 + 68'(d);
            if (acc > {4'd1, 64'd0})
            begin
                tk_num_high = 2;
                tk_num_low = '0;
            end
            else
            begin
                tk_num_high = acc[65:64];
                tk_num_low = acc[63:0];
            end
        end
    endfunction

    task finish_number(input logic [POS_W-1:0] endpos);
        bit too_big;
        too_big = 1;
        if (tk_mode == PS_NUM_INT)
        begin
            if (tk_negative)
                too_big = (tk_num_high != 0) || (tk_num_low > 64'h8000000000000000);
            else
                too_big = (tk_num_high >= 2);
        end
        emit_value(too_big ? EV_FLOAT : EV_INT, tk_token_begin, endpos);
        after_value();
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task start_value(input logic [7:0] c, input logic [POS_W-1:0] pos);
        if (c <= 8'h20)
            return;
        if (c == "t" || c == "f" || c == "n")
        begin
            tk_lit_step = (c == "t") ? 1 : (c == "f") ? 5 : 10;
            tk_mode = PS_LIT;
        end
        else if (c == "\"")
        begin
            tk_token_begin = pos + 1'b1;
            tk_mode = PS_STR;
        end
        else if (c == "-" || c == "." || is_digit(c))
        begin
            tk_token_begin = pos;
            tk_num_low = '0;
            tk_num_high = '0;
            tk_negative = (c == "-");
            if (c == ".")
                tk_mode = PS_NUM_FRAC;
            else
                tk_mode = PS_NUM_INT;
            if (is_digit(c))
                add_digit(c - "0");
        end
        else if (c == "[")
            open_container(0);
        else if (c == "{")
            open_container(1);
        else if (c == "]" && tk_mode == PS_ARR_VALUE)
            close_container(EV_END_ARR);
        else
            raise_fault(ERR_CHAR);
    endtask

    function automatic bit number_takes(input logic [7:0] c);
        bit e;
        e = (c == "e" || c == "E");
        case (tk_mode)
            PS_NUM_INT:
            begin
                if (is_digit(c))
                begin
                    add_digit(c - "0");
                    return 1;
                end
                if (c == ".")
                begin
                    tk_mode = PS_NUM_FRAC;
                    return 1;
                end
                if (e)
                begin
                    tk_mode = PS_NUM_ESIGN;
                    return 1;
                end
                return 0;
            end
            PS_NUM_FRAC:
            begin
                if (is_digit(c))
                    return 1;
                if (e)
                begin
                    tk_mode = PS_NUM_ESIGN;
                    return 1;
                end
                return 0;
            end
            PS_NUM_ESIGN:
            begin
                if (c == "+" || c == "-" || is_digit(c))
                begin
                    tk_mode = PS_NUM_EXP;
                    return 1;
                end
                return 0;
            end
            default: return is_digit(c);
        endcase
    endfunction

    task consume_byte(input logic [7:0] c, input logic [POS_W-1:0] pos);
        string lit_text;
        lit_text = "truefalsenull";
        if (tk_mode >= PS_NUM_INT && tk_mode <= PS_NUM_EXP)
        begin
            if (number_takes(c))
                return;
            finish_number(pos);
        end
        case (tk_mode)
            PS_TOP_VALUE, PS_ARR_VALUE, PS_MEMBER_VALUE: start_value(c, pos);
            PS_OBJ_KEY:
            begin
                if (c > 8'h20)
                begin
                    if (c == "}")
                        close_container(EV_END_OBJ);
                    else if (c == "\"")
                    begin
                        tk_key_begin = pos + 1'b1;
                        tk_mode = PS_KEY_STR;
                    end
                    else
                        raise_fault(ERR_KEY);
                end
            end
            PS_KEY_STR:
            begin
                if (c == "\\")
                    tk_mode = PS_KEY_ESC;
                else if (c == "\"")
                begin
                    tk_key_end = pos;
                    tk_key_valid = 1;
                    tk_mode = PS_COLON;
                end
            end
            PS_KEY_ESC: tk_mode = PS_KEY_STR;
            PS_COLON:
            begin
                if (c > 8'h20)
                begin
                    if (c == ":")
                        tk_mode = PS_MEMBER_VALUE;
                    else
                        raise_fault(ERR_COLON);
                end
            end
            PS_OBJ_NEXT:
            begin
                if (c > 8'h20)
                begin
                    if (c == ",")
                        tk_mode = PS_OBJ_KEY;
                    else if (c == "}")
                        close_container(EV_END_OBJ);
                    else
                        raise_fault(ERR_BRACE);
                end
            end
            PS_ARR_NEXT:
            begin
                if (c > 8'h20)
                begin
                    if (c == ",")
                        tk_mode = PS_ARR_VALUE;
                    else if (c == "]")
                        close_container(EV_END_ARR);
                    else
                        raise_fault(ERR_BRACKET);
                end
            end
            PS_STR:
            begin
                if (c == "\\")
                    tk_mode = PS_STR_ESC;
                else if (c == "\"")
                begin
                    emit_value(EV_STRING, tk_token_begin, pos);
                    after_value();
                end
            end
            PS_STR_ESC: tk_mode = PS_STR;
            PS_LIT:
            begin
                if (tk_lit_step > 12 || c != lit_text[tk_lit_step])
                begin
                    raise_fault(ERR_LIT);
                end
                else
                begin
                    tk_lit_step++;
                    if (tk_lit_step == 4 || tk_lit_step == 9 || tk_lit_step == 13)
                    begin
                        emit_value(tk_lit_step == 4 ? EV_TRUE :
                                   tk_lit_step == 9 ? EV_FALSE : EV_NULL, '0, '0);
                        tk_lit_step = 0;
                        after_value();
                    end
                end
            end
            default: ;
        endcase
    endtask

    task finish_document();
        logic [3:0] code;
        if (tk_mode >= PS_NUM_INT && tk_mode <= PS_NUM_EXP)
            finish_number(tk_offset);
        case (tk_mode)
            PS_TAIL:   code = ERR_NONE;
            PS_FAULT:  code = tk_fault;
            PS_OBJ_KEY: code = ERR_KEY;
            PS_COLON:  code = ERR_COLON;
            PS_OBJ_NEXT: code = ERR_BRACE;
            PS_ARR_NEXT: code = ERR_BRACKET;
            PS_KEY_STR, PS_KEY_ESC, PS_STR, PS_STR_ESC: code = ERR_STRING;
            PS_LIT:    code = ERR_LIT;
            default:   code = ERR_CHAR;
        endcase
        if (tk_mode == PS_TAIL)
            emit_event(EV_DONE, '0, '0, 0, ERR_NONE);
        else
            emit_event(EV_ERROR, '0, '0, 0, code);
    endtask

    task predict_events(input in_item_t item);
        step_events.delete();
        if (item.end_mark)
        begin
            finish_document();
            tk_reset();
        end
        else
        begin
            consume_byte(item.char_code, tk_offset);
            tk_offset = tk_offset + 1'b1;
        end
        if (step_events.size() > 0)
            step_events[step_events.size()-1].last_of_item = 1'b1;
        foreach (step_events[i])
            expected_events.push_back(step_events[i]);
    endtask

    // ------------------------------------------------------------------------
    // Document generation
    // ------------------------------------------------------------------------
    logic [7:0] doc[$];

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            doc.push_back(s[i]);
    endtask

    task flush_doc();
        in_item_t it;
        foreach (doc[i])
        begin
            it.char_code = doc[i];
            it.end_mark = 1'b0;
            pending_bytes.push_back(it);
        end
        it.char_code = 8'($urandom);
        it.end_mark = 1'b1;
        pending_bytes.push_back(it);
        doc.delete();
    endtask

    task add_doc(input string s);
        add_text(s);
        flush_doc();
    endtask

    task add_space();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n)
            doc.push_back(8'($urandom_range(0, 32)));
    endtask

    task add_string_body();
        int n;
        logic [7:0] c;
        n = $urandom_range(0, 6);
        doc.push_back("\"");
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                doc.push_back("\\");
                doc.push_back(8'($urandom));
            end
            else
            begin
                c = 8'($urandom);
                if (c == "\"" || c == "\\")
                    c = "a";
                doc.push_back(c);
            end
        end
        doc.push_back("\"");
    endtask

    task add_number();
        int n;
        case ($urandom_range(0, 9))
            0: add_text("18446744073709551615");
            1: add_text("18446744073709551616");
            2: add_text("18446744073709551617");
            3: add_text("-9223372036854775808");
            4: add_text("-9223372036854775809");
            5: add_text($urandom_range(0, 1) ? "-" : ".");
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    doc.push_back("-");
                n = $urandom_range(1, 22);
                repeat (n)
                    doc.push_back(8'("0" + $urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0)
                begin
                    doc.push_back(".");
                    repeat ($urandom_range(0, 3))
                        doc.push_back(8'("0" + $urandom_range(0, 9)));
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    doc.push_back($urandom_range(0, 1) ? "e" : "E");
                    case ($urandom_range(0, 2))
                        0: doc.push_back("+");
                        1: doc.push_back("-");
                        default: ;
                    endcase
                    repeat ($urandom_range(0, 2))
                        doc.push_back(8'("0" + $urandom_range(0, 9)));
                end
            end
        endcase
    endtask

    task automatic add_value(input int level);
        int kind;
        int n;
        kind = $urandom_range(0, (level < 4) ? 6 : 4);
        add_space();
        case (kind)
            0: add_text($urandom_range(0, 2) == 0 ? "true" :
                         $urandom_range(0, 1) ? "false" : "null");
            1, 2: add_string_body();
            3, 4: add_number();
            5:
            begin
                doc.push_back("[");
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    add_value(level + 1);
                    add_space();
                    if (i < n - 1 || $urandom_range(0, 4) == 0)
                        doc.push_back(",");
                end
                add_space();
                doc.push_back("]");
            end
            default:
            begin
                doc.push_back("{");
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    add_space();
                    add_string_body();
                    add_space();
                    doc.push_back(":");
                    add_value(level + 1);
                    add_space();
                    if (i < n - 1 || $urandom_range(0, 4) == 0)
                        doc.push_back(",");
                end
                add_space();
                doc.push_back("}");
            end
        endcase
    endtask

    task add_random_doc();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            // Pure noise.
            repeat ($urandom_range(0, 12))
                doc.push_back(8'($urandom));
        end
        else if (pick == 1)
        begin
            repeat ($urandom_range(30, 34))
                doc.push_back($urandom_range(0, 1) ? "[" : "{");
        end
        else
        begin
            add_value(0);
            add_space();
            if (pick < 5 && doc.size() > 0)
                doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom);
            else if (pick < 8 && doc.size() > 1)
                doc = doc[0:$urandom_range(0, doc.size() - 2)];
            else if (pick < 10)
                repeat ($urandom_range(1, 4))
                    doc.push_back(8'($urandom));
        end
        flush_doc();
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of requests with random gaps.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                in_item_t next_item;
                next_item = pending_bytes.pop_front();
                // The payload holds until taken, so it can be predicted now.
                predict_events(next_item);
                in_data <= next_item;
                in_valid <= 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall pattern, with one long hold-off to back up the block.
    // ------------------------------------------------------------------------
    int stall_phase;
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase = 0;
            hold_left = 0;
            hold_done = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && events_seen >= 300)
        begin
            hold_done = 1;
            hold_left = 250;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 192;
            if (stall_phase < 64)
                out_stall <= 1'b0;
            else if (stall_phase < 128)
                out_stall <= ($urandom_range(0, 2) == 0);
            else
                out_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task report_mismatch(input string what, input longint unsigned want,
                         input longint unsigned got);
        mismatch_count++;
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            out_item_t want;
            events_seen++;
            if (expected_events.size() == 0)
            begin
                report_mismatch("unexpected event, kind", 0, out_data.event_kind);
            end
            else
            begin
                want = expected_events.pop_front();
                if (out_data.event_kind !== want.event_kind)
                    report_mismatch("event_kind", want.event_kind, out_data.event_kind);
                if (out_data.value_start !== want.value_start)
                    report_mismatch("value_start", want.value_start, out_data.value_start);
                if (out_data.value_end !== want.value_end)
                    report_mismatch("value_end", want.value_end, out_data.value_end);
                if (out_data.has_name !== want.has_name)
                    report_mismatch("has_name", want.has_name, out_data.has_name);
                if (out_data.name_start !== want.name_start)
                    report_mismatch("name_start", want.name_start, out_data.name_start);
                if (out_data.name_end !== want.name_end)
                    report_mismatch("name_end", want.name_end, out_data.name_end);
                if (out_data.nest_depth !== want.nest_depth)
                    report_mismatch("nest_depth", want.nest_depth, out_data.nest_depth);
                if (out_data.error_code !== want.error_code)
                    report_mismatch("error_code", want.error_code, out_data.error_code);
                if (out_data.last_of_item !== want.last_of_item)
                    report_mismatch("last_of_item", want.last_of_item, out_data.last_of_item);
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        events_seen = 0;
        tk_reset();
        rst_n = 1'b0;

        // Directed documents: every token kind, every error, range limits.
        add_doc("{\"a\":[true,false,null,-12,.5e,1E+3,\"x\\\"y\",],\"b\\\"\":{},}");
        add_doc("tru");
        add_doc("trx");
        add_doc("{1");
        add_doc("{\"k\" 1");
        add_doc("{\"k\":1]");
        add_doc("[1}");
        add_doc("#");
        add_doc("\"abc");
        add_doc("{\"ab");
        add_doc("-");
        add_doc(".");
        add_doc("18446744073709551616");
        add_doc("18446744073709551617");
        add_doc("-9223372036854775808");
        add_doc("-9223372036854775809 ");
        add_doc("[]x]");
        add_doc("");
        add_doc("[1,2");
        add_doc("{\"k\":");
        doc.push_back(8'hFF);
        flush_doc();
        doc.push_back(8'h00);
        doc.push_back(8'h20);
        add_text("[7]");
        flush_doc();
        repeat (33)
            doc.push_back("[");
        flush_doc();

        while (pending_bytes.size() < 1750)
            add_random_doc();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("[json_stream_tokenizer_top] OK");
        else
            $display("[json_stream_tokenizer_top] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[json_stream_tokenizer_top] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jst_pkg.sv
rtl/jst_stack.sv
rtl/jst_out_fifo.sv
rtl/jst_core.sv
rtl/json_stream_tokenizer_top.sv
tb/json_stream_tokenizer_top_tb.sv
